@@ rtl/ir_pulse_distance_frame_encoder_assert.svh @@
// Assertion macros used by the IR frame encoder sequencer.
`ifndef IR_PULSE_DISTANCE_FRAME_ENCODER_ASSERT_SVH
`define IR_PULSE_DISTANCE_FRAME_ENCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPDE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipde assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IPDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipde assertion failed");

`endif

@@ rtl/ipde_pkg.sv @@
// Types and constants shared by the IR pulse-distance frame encoder.
`timescale 1ns / 1ps
package ipde_pkg;

  localparam int DUR_W = 16;
  localparam int CNT_W = 6;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_MARK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SPACE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE   = 3'd4;

  // Reset values of the timing registers, in microseconds.
  localparam logic [DUR_W-1:0] RST_HEADER_MARK  = 16'd9000;
  localparam logic [DUR_W-1:0] RST_HEADER_SPACE = 16'd4500;
  localparam logic [DUR_W-1:0] RST_BIT_MARK     = 16'd560;
  localparam logic [DUR_W-1:0] RST_ONE_SPACE    = 16'd1690;
  localparam logic [DUR_W-1:0] RST_ZERO_SPACE   = 16'd560;

  // Kind of symbol being emitted.
  localparam logic [1:0] SYM_HDR = 2'd0;
  localparam logic [1:0] SYM_BIT = 2'd1;
  localparam logic [1:0] SYM_TRL = 2'd2;

  typedef struct packed {
    logic       load;
    logic       shift;
    logic       emit;
    logic [1:0] kind;
  } ipde_ctrl_t;

endpackage

@@ rtl/ir_pulse_distance_frame_encoder.sv @@
// Top level of the IR pulse-distance frame encoder with its timing registers.
// On acceptance the sequencer enters its header state, which emits the header beat.
// Throughput: one beat per cycle while the output is not stalled; a frame is the
// header beat, one beat per payload bit and the trailer beat, the sequencer stepping
// the payload shift register one bit per beat; a new frame waits until it is idle.
// Reset: synchronous, active low; timing registers return to their defaults.
`timescale 1ns / 1ps
module ir_pulse_distance_frame_encoder import ipde_pkg::*; #(
  parameter int MAX_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DUR_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [MAX_BITS-1:0]  in_frame_bits,
  input  logic [CNT_W-1:0]     in_bit_count,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DUR_W-1:0]     out_mark_us,
  output logic [DUR_W-1:0]     out_space_us,
  output logic                 out_last
);

  logic [DUR_W-1:0] hdr_mark_r;
  logic [DUR_W-1:0] hdr_space_r;
  logic [DUR_W-1:0] bit_mark_r;
  logic [DUR_W-1:0] one_space_r;
  logic [DUR_W-1:0] zero_space_r;

  logic             out_valid_r;
  logic [DUR_W-1:0] mark_r;
  logic [DUR_W-1:0] space_r;
  logic             last_r;
  logic [DUR_W-1:0] mark_nxt;
  logic [DUR_W-1:0] space_nxt;

  logic       slot_free;
  logic       msb;
  ipde_ctrl_t ctrl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_mark_r   <= RST_HEADER_MARK;
      hdr_space_r  <= RST_HEADER_SPACE;
      bit_mark_r   <= RST_BIT_MARK;
      one_space_r  <= RST_ONE_SPACE;
      zero_space_r <= RST_ZERO_SPACE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER_MARK:  hdr_mark_r   <= cfg_wdata;
        REG_HEADER_SPACE: hdr_space_r  <= cfg_wdata;
        REG_BIT_MARK:     bit_mark_r   <= cfg_wdata;
        REG_ONE_SPACE:    one_space_r  <= cfg_wdata;
        REG_ZERO_SPACE:   zero_space_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // The output register can take a new beat when empty or being drained.
  assign slot_free = !out_valid_r || !out_stall;

  ipde_seq #(
    .MAX_BITS(MAX_BITS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_bit_count (in_bit_count),
    .slot_free    (slot_free),
    .in_stall     (in_stall),
    .ctrl         (ctrl)
  );

  ipde_shift #(
    .MAX_BITS(MAX_BITS)
  ) u_shift (
    .clk           (clk),
    .ctrl          (ctrl),
    .in_frame_bits (in_frame_bits),
    .msb           (msb)
  );

  always_comb begin
    case (ctrl.kind)
      SYM_HDR: begin
        mark_nxt  = hdr_mark_r;
        space_nxt = hdr_space_r;
      end
      SYM_BIT: begin
        mark_nxt  = bit_mark_r;
        space_nxt = msb ? one_space_r : zero_space_r;
      end
      default: begin
        mark_nxt  = bit_mark_r;
        space_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      mark_r  <= mark_nxt;
      space_r <= space_nxt;
      last_r  <= (ctrl.kind == SYM_TRL);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_mark_us  = mark_r;
  assign out_space_us = space_r;
  assign out_last     = last_r;

endmodule

@@ rtl/ipde_shift.sv @@
// Payload shift register that presents the next bit to send at its top.
`timescale 1ns / 1ps
module ipde_shift import ipde_pkg::*; #(
  parameter int MAX_BITS = 48
) (
  input  logic                clk,
  input  ipde_ctrl_t          ctrl,
  input  logic [MAX_BITS-1:0] in_frame_bits,
  output logic                msb
);

  logic [MAX_BITS-1:0] sh_r;
  logic [MAX_BITS-1:0] sh_nxt;

  always_comb begin
    sh_nxt = sh_r;
    if (ctrl.load) begin
      sh_nxt = in_frame_bits;
    end else if (ctrl.shift) begin
      sh_nxt = {sh_r[MAX_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
  end

  assign msb = sh_r[MAX_BITS-1];

endmodule

@@ rtl/ipde_seq.sv @@
// Frame sequencer: header, one symbol per payload bit, then the trailer.
`timescale 1ns / 1ps
module ipde_seq import ipde_pkg::*; #(
  parameter int MAX_BITS = 48
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CNT_W-1:0] in_bit_count,
  input  logic             slot_free,
  output logic             in_stall,
  output ipde_ctrl_t       ctrl
);

  `include "ir_pulse_distance_frame_encoder_assert.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HDR  = 2'd1;
  localparam logic [1:0] S_BIT  = 2'd2;
  localparam logic [1:0] S_TRL  = 2'd3;

  localparam logic [CNT_W-1:0] MaxCount = CNT_W'(MAX_BITS);

  logic [1:0]       state_r;
  logic [1:0]       state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ctrl.load  = 1'b0;
    ctrl.shift = 1'b0;
    ctrl.emit  = 1'b0;
    ctrl.kind  = SYM_HDR;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          ctrl.load = 1'b1;
          // Counts beyond the frame width saturate.
          cnt_nxt   = (in_bit_count > MaxCount) ? MaxCount : in_bit_count;
          state_nxt = S_HDR;
        end
      end
      S_HDR: begin
        ctrl.kind = SYM_HDR;
        if (slot_free) begin
          ctrl.emit = 1'b1;
          state_nxt = (cnt_r == '0) ? S_TRL : S_BIT;
        end
      end
      S_BIT: begin
        ctrl.kind = SYM_BIT;
        if (slot_free) begin
          ctrl.emit  = 1'b1;
          ctrl.shift = 1'b1;
          cnt_nxt    = cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = S_TRL;
          end
        end
      end
      S_TRL: begin
        ctrl.kind = SYM_TRL;
        if (slot_free) begin
          ctrl.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `IPDE_ASSERT_NEXT(a_accept_to_hdr, clk, rst_n, accept, state_r == S_HDR)
  `IPDE_ASSERT_NEXT(a_trl_to_idle, clk, rst_n,
                    ctrl.emit && (ctrl.kind == SYM_TRL), state_r == S_IDLE)
  `IPDE_ASSERT_NOW(a_bit_cnt_live, clk, rst_n, state_r == S_BIT, cnt_r != '0)
  `IPDE_ASSERT_NEXT(a_empty_frame, clk, rst_n,
                    (state_r == S_HDR) && ctrl.emit && (cnt_r == '0), state_r == S_TRL)

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the IR pulse-distance frame encoder.
`timescale 1ns / 1ps
module tb;
  import ipde_pkg::*;

  localparam int FRAME_W = 48;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT = 2000;
  localparam int DIR_N = 18;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 44;

  typedef struct packed {
    logic [DUR_W-1:0] mark;
    logic [DUR_W-1:0] space;
    logic             last;
  } symbol_t;

  // A frame request; when typed is set, the expected beats follow from the
  // four durations given here rather than from the encoder model.
  typedef struct packed {
    logic [FRAME_W-1:0] bits;
    logic [CNT_W-1:0]   count;
    logic               typed;
    logic [DUR_W-1:0]   hm;
    logic [DUR_W-1:0]   hs;
    logic [DUR_W-1:0]   bm;
    logic [DUR_W-1:0]   bs;
  } frame_req_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DUR_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [FRAME_W-1:0]   in_frame_bits;
  logic [CNT_W-1:0]     in_bit_count;
  logic                 out_valid;
  logic                 out_stall;
  logic [DUR_W-1:0]     out_mark_us;
  logic [DUR_W-1:0]     out_space_us;
  logic                 out_last;

  // Local copy of the timing registers.
  logic [DUR_W-1:0] t_hdr_mark = RST_HEADER_MARK;
  logic [DUR_W-1:0] t_hdr_space = RST_HEADER_SPACE;
  logic [DUR_W-1:0] t_bit_mark = RST_BIT_MARK;
  logic [DUR_W-1:0] t_one_space = RST_ONE_SPACE;
  logic [DUR_W-1:0] t_zero_space = RST_ZERO_SPACE;

  symbol_t pending_symbols[$];
  symbol_t want_sym;
  int      mismatches = 0;
  int      idle_cycles = 0;
  bit      calm = 1'b0;
  bit      hold_req = 1'b0;

  frame_req_t dir_tab [0:DIR_N-1] = '{
    {48'h0000_0000_0000, 6'd0,  1'b1, 16'd9000, 16'd4500, 16'd560, 16'd0},
    {48'h8000_0000_0000, 6'd1,  1'b1, 16'd9000, 16'd4500, 16'd560, 16'd1690},
    {48'h7FFF_FFFF_FFFF, 6'd1,  1'b1, 16'd9000, 16'd4500, 16'd560, 16'd560},
    {48'hFFFF_FFFF_FFFF, 6'd0,  1'b1, 16'd9000, 16'd4500, 16'd560, 16'd0},
    {48'hFFFF_FFFF_FFFF, 6'd1,  1'b1, 16'd9000, 16'd4500, 16'd560, 16'd1690},
    {48'hFFFF_FFFF_FFFF, 6'd48, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
    {48'h0000_0000_0000, 6'd48, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
    {48'hAAAA_AAAA_AAAA, 6'd48, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
    {48'h5555_5555_5555, 6'd48, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
    {48'h0000_0000_0001, 6'd48, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
    {48'h0000_0000_0001, 6'd47, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
    {48'h8000_0000_0001, 6'd2,  1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
    {48'h4000_0000_0000, 6'd2,  1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
    {48'hFFFF_FFFF_FFFF, 6'd49, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
    {48'h1234_5678_9ABC, 6'd63, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
    {48'hF0F0_F0F0_F0F0, 6'd32, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
    {48'h0F0F_0F0F_0F0F, 6'd31, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0},
    {48'hDEAD_BEEF_CAFE, 6'd62, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0}
  };

  ir_pulse_distance_frame_encoder #(
    .MAX_BITS(FRAME_W)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_frame_bits(in_frame_bits),
    .in_bit_count (in_bit_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_mark_us  (out_mark_us),
    .out_space_us (out_space_us),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 48);
  endfunction

  // Appends the beats of one frame: header, one beat per payload bit from the
  // top, then the trailer. Counts beyond the frame width are clipped.
  function automatic void encode_frame(logic [FRAME_W-1:0] bits, logic [CNT_W-1:0] count);
    int n;
    n = (count > FRAME_W) ? FRAME_W : int'(count);
    pending_symbols.push_back({t_hdr_mark, t_hdr_space, 1'b0});
    for (int i = 0; i < n; i++) begin
      pending_symbols.push_back({t_bit_mark,
                                 bits[FRAME_W-1-i] ? t_one_space : t_zero_space, 1'b0});
    end
    pending_symbols.push_back({t_bit_mark, 16'd0, 1'b1});
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic offer_frame(input frame_req_t req);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_frame_bits <= req.bits;
    in_bit_count <= req.count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (req.typed) begin
      pending_symbols.push_back({req.hm, req.hs, 1'b0});
      if (req.count == 1) pending_symbols.push_back({req.bm, req.bs, 1'b0});
      pending_symbols.push_back({req.bm, 16'd0, 1'b1});
    end else begin
      encode_frame(req.bits, req.count);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all eight indexes; the three past the last register must be ignored.
  task automatic program_timing(input int setting);
    logic [DUR_W-1:0] v;
    for (int r = 0; r < 8; r++) begin
      case (setting)
        0: v = '0;
        1: v = '1;
        2: begin
          case (CFG_IDX_W'(r))
            REG_HEADER_MARK:  v = RST_HEADER_MARK;
            REG_HEADER_SPACE: v = RST_HEADER_SPACE;
            REG_BIT_MARK:     v = RST_BIT_MARK;
            REG_ONE_SPACE:    v = RST_ONE_SPACE;
            REG_ZERO_SPACE:   v = RST_ZERO_SPACE;
            default:          v = DUR_W'($urandom);
          endcase
        end
        default: v = DUR_W'($urandom);
      endcase
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(r);
      cfg_wdata <= v;
      @(posedge clk);
      case (CFG_IDX_W'(r))
        REG_HEADER_MARK:  t_hdr_mark = v;
        REG_HEADER_SPACE: t_hdr_space = v;
        REG_BIT_MARK:     t_bit_mark = v;
        REG_ONE_SPACE:    t_one_space = v;
        REG_ZERO_SPACE:   t_zero_space = v;
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off when asked for.
  initial begin
    int len;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        len = calm ? 0 : idle_len();
        out_stall <= (len != 0);
        if (len != 0) repeat (len) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_symbols.size() == 0) begin
        report_mismatch("beat with nothing pending", out_mark_us, 0);
      end else begin
        want_sym = pending_symbols.pop_front();
        if (out_mark_us !== want_sym.mark)
          report_mismatch("mark_us", out_mark_us, want_sym.mark);
        if (out_space_us !== want_sym.space)
          report_mismatch("space_us", out_space_us, want_sym.space);
        if (out_last !== want_sym.last)
          report_mismatch("last", out_last, want_sym.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $realtime, IDLE_LIMIT);
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    frame_req_t req;
    int pick;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_frame_bits <= '0;
    in_bit_count <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < DIR_N; k++) offer_frame(dir_tab[k]);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      program_timing(ph);
      calm = (ph == 2);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // Long receiver hold-off while frames keep coming, so the input backs up.
        if (ph == 1 && k == 10) hold_req = 1'b1;
        if (ph == 3 && k == 20) drain();
        req = '0;
        req.bits = {16'($urandom), 32'($urandom)};
        pick = $urandom_range(0, 99);
        if (pick < 8) req.count = 6'd0;
        else if (pick < 16) req.count = 6'($urandom_range(49, 63));
        else if (pick < 26) req.count = 6'd48;
        else req.count = 6'($urandom_range(1, 47));
        pick = $urandom_range(0, 19);
        if (pick == 0) req.bits = '1;
        else if (pick == 1) req.bits = '0;
        offer_frame(req);
      end
      drain();
    end

    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
